>>> rtl/core/isqrt_pkg.sv
// isqrt_pkg: widths, controller/datapath link types and the leading-one encoder
// shared by the integer square root controller, datapath and top level.
// no dependencies.
package isqrt_pkg;

  // operand and root geometry
  localparam int DATA_WIDTH = 32;
  localparam int ROOT_W     = DATA_WIDTH / 2;
  localparam int IDX_W      = $clog2(DATA_WIDTH);
  localparam int BIT_W      = $clog2(ROOT_W);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new operand
    logic setup;  // seed the root from the leading one
    logic step;   // resolve one root bit
  } isqrt_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic special;  // zero or negative operand, root is 0
    logic single;   // seed already is the final root
    logic last;     // current step resolves bit 0
  } isqrt_stat_t;

  // index of the highest set bit, 0 for a zero word
  function automatic logic [IDX_W-1:0] lead_index(input logic [DATA_WIDTH-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

>>> rtl/core/integer_square_root.sv
// integer_square_root: floor square root of a signed 32-bit operand.
// depends on isqrt_pkg, isqrt_ctrl and isqrt_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | start high, busy low | operand[31:0] signed
//   result   | done, one cycle      | root[15:0], negative_error
//
// an operand is seeded from its leading one in a setup step, then narrowed
// one root bit per step down to bit 0; zero and negative operands, and
// those whose seed already is the root, finish in setup. busy stays high
// throughout; the single square-and-compare unit resolves one root bit
// per cycle. done is high in the cycle after the last step and a new
// operand may transfer in that cycle. rst is synchronous and returns the
// controller to idle; results cannot be stalled.
module integer_square_root
  import isqrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] operand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root,
  output logic                  negative_error
);

  isqrt_cmd_t  cmd;
  isqrt_stat_t stat;

  // sequencer
  isqrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // registers and square-compare unit
  isqrt_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .operand        (operand),
    .stat           (stat),
    .root           (root),
    .negative_error (negative_error)
  );

endmodule

>>> rtl/core/isqrt_ctrl.sv
// isqrt_ctrl: sequencer for the square root search, drives datapath commands
// and the busy/done handshake.
// depends on isqrt_pkg.
module isqrt_ctrl
  import isqrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  isqrt_stat_t stat,
  output isqrt_cmd_t  cmd,
  output logic        busy,
  output logic        done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ITER
  } state_t;

  state_t state;

  // commands follow the state directly; load also needs start
  always_comb begin
    cmd.load  = (state == ST_IDLE) && start;
    cmd.setup = (state == ST_SETUP);
    cmd.step  = (state == ST_ITER);
  end

  assign busy = (state != ST_IDLE);

  // state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) state <= ST_SETUP;
        end
        ST_SETUP: begin
          if (stat.special || stat.single) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (stat.last) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result is only shown once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // the strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held");

  // an accepted operand starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted operand did not start work");

  // a strobe only follows work
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("result strobe without work");

endmodule

>>> rtl/core/isqrt_datapath.sv
// isqrt_datapath: operand, root and bit position registers with the
// square-and-compare unit, one root bit per step.
// depends on isqrt_pkg.
module isqrt_datapath
  import isqrt_pkg::*;
(
  input  logic                  clk,
  input  isqrt_cmd_t            cmd,
  input  logic [DATA_WIDTH-1:0] operand,
  output isqrt_stat_t           stat,
  output logic [ROOT_W-1:0]     root,
  output logic                  negative_error
);

  logic [DATA_WIDTH-1:0] n;
  logic [BIT_W-1:0]      bitpos;
  logic [IDX_W-1:0]      lead;
  logic [BIT_W-1:0]      half;
  logic [ROOT_W-1:0]     trial;
  logic [DATA_WIDTH-1:0] trial_sq;
  logic                  is_zero;

  // bracket from the leading one: root lies in [2^half, 2^(half+1))
  assign lead    = lead_index(n);
  assign half    = lead[IDX_W-1:1];
  assign is_zero = (n == '0);

  // try setting the current bit and square the candidate
  assign trial    = root | (ROOT_W'(1) << bitpos);
  assign trial_sq = trial * trial;

  always_comb begin
    stat.special = negative_error || is_zero;
    stat.single  = (half == '0);
    stat.last    = (bitpos == '0);
  end

  // operand capture, seed and bit-by-bit narrowing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n              <= operand;
      negative_error <= operand[DATA_WIDTH-1];
    end
    if (cmd.setup) begin
      if (negative_error || is_zero) begin
        root <= '0;
      end else begin
        root <= ROOT_W'(1) << half;
      end
      bitpos <= half - BIT_W'(1);
    end
    if (cmd.step) begin
      if (trial_sq <= n) root <= trial;
      bitpos <= bitpos - BIT_W'(1);
    end
  end

endmodule
